/* rtl/skis_pkg.sv */
package skis_pkg;

  // default sizing
  localparam int CAPACITY_DEF   = 1024;
  localparam int KEY_DIGITS_DEF = 13;

  // fixed field widths
  localparam int KEY_W  = 52;
  localparam int SLOT_W = 10;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // input word
  typedef struct packed {
    opcode_t            opcode;
    logic [KEY_W-1:0]   key_bcd;
  } in_word_t;

  // result word
  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
  } out_word_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RDIDX,
    S_RDKEY,
    S_CMP
  } state_t;

  // memory port strobes
  typedef struct packed {
    logic ks_we;
    logic ks_re;
    logic so_we;
    logic so_re;
  } mem_ctl_t;

  // compare flags, probe against search key
  typedef struct packed {
    logic eq;
    logic lt;
    logic gt;
  } cmp_t;

endpackage

/* rtl/skis_cmp.sv */
module skis_cmp #(
  parameter int KW = 52
) (
  input  logic [KW-1:0] probe,
  input  logic [KW-1:0] key,
  output skis_pkg::cmp_t res
);

  // single magnitude compare shared by insert and lookup
  always_comb begin
    res.eq = (probe == key);
    res.lt = (probe < key);
    res.gt = (probe > key);
  end

endmodule

/* rtl/skis_store.sv */
module skis_store #(
  parameter int DEPTH = 1024,
  parameter int SW    = 10,
  parameter int KW    = 52
) (
  input  logic                clk,
  input  skis_pkg::mem_ctl_t  ctl,
  input  logic [SW-1:0]       ks_waddr,
  input  logic [KW-1:0]       ks_wdata,
  input  logic [SW-1:0]       ks_raddr,
  output logic [KW-1:0]       ks_rdata,
  input  logic [SW-1:0]       so_waddr,
  input  logic [SW-1:0]       so_wdata,
  input  logic [SW-1:0]       so_raddr,
  output logic [SW-1:0]       so_rdata
);

  logic [KW-1:0] ks_mem [DEPTH];
  logic [SW-1:0] so_mem [DEPTH];

  // keys in arrival order
  always_ff @(posedge clk) begin
    if (ctl.ks_we) begin
      ks_mem[ks_waddr] <= ks_wdata;
    end
    if (ctl.ks_re) begin
      ks_rdata <= ks_mem[ks_raddr];
    end
  end

  // slot numbers in ascending key order
  always_ff @(posedge clk) begin
    if (ctl.so_we) begin
      so_mem[so_waddr] <= so_wdata;
    end
    if (ctl.so_re) begin
      so_rdata <= so_mem[so_raddr];
    end
  end

endmodule

/* rtl/sorted_key_index_insert_search.sv */
// Sorted key table with insert and binary-search lookup. Keys land in arrival
// order in a key memory; a second memory holds the slot numbers sorted by key.
// One word is worked on at a time and in_ready is low meanwhile, though a new
// word is taken while the previous result still waits on the output register.
// Each step of the sequencer runs through its states in order: decide, read the
// sorted index, read the key at that slot, compare in the single shared
// comparator. An insert takes a step for each stored entry that it moves; a
// lookup is a binary search over the n stored keys. The index is read first and
// then the key at that slot, through the single read port of each memory. An
// insert into a full table returns the full status and changes nothing. Only
// entries below the entry count are read, so no clearing pass runs after reset.
module sorted_key_index_insert_search #(
  parameter int CAPACITY   = skis_pkg::CAPACITY_DEF,
  parameter int KEY_DIGITS = skis_pkg::KEY_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  skis_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output skis_pkg::out_word_t out_data
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (4 * KEY_DIGITS < skis_pkg::KEY_W) ? 4 * KEY_DIGITS : skis_pkg::KEY_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  skis_pkg::state_t    state_r, state_nxt;
  skis_pkg::opcode_t   op_r, op_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic [SW-1:0]       pos_r, pos_nxt;
  logic [SW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  skis_pkg::out_word_t out_data_r, out_data_nxt;

  skis_pkg::mem_ctl_t  ctl;
  logic [SW-1:0]       ks_waddr, ks_raddr, so_waddr, so_wdata, so_raddr, so_rdata;
  logic [KW-1:0]       ks_wdata, ks_rdata;
  skis_pkg::cmp_t      cmp;

  logic                in_acc;
  logic                out_free;
  logic                check_fin;
  logic                cmp_fin;
  logic                fin_go;
  logic [CW:0]         mid_sum;
  logic [SW-1:0]       mid;
  logic [SW-1:0]       fresh;

  skis_store #(
    .DEPTH (CAPACITY),
    .SW    (SW),
    .KW    (KW)
  ) u_store (
    .clk      (clk),
    .ctl      (ctl),
    .ks_waddr (ks_waddr),
    .ks_wdata (ks_wdata),
    .ks_raddr (ks_raddr),
    .ks_rdata (ks_rdata),
    .so_waddr (so_waddr),
    .so_wdata (so_wdata),
    .so_raddr (so_raddr),
    .so_rdata (so_rdata)
  );

  skis_cmp #(
    .KW (KW)
  ) u_cmp (
    .probe (ks_rdata),
    .key   (key_r),
    .res   (cmp)
  );

  // common decisions
  assign in_ready  = (state_r == skis_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign fresh     = count_r[SW-1:0];
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} - (CW + 1)'(1);
  assign mid       = SW'(mid_sum >> 1);
  assign check_fin = (op_r == skis_pkg::OP_INSERT) ? ((count_r == CAP_C) || (hi_r == '0))
                                                   : (lo_r >= hi_r);
  assign cmp_fin   = (op_r == skis_pkg::OP_INSERT) ? !cmp.gt : cmp.eq;
  assign fin_go    = out_free && (((state_r == skis_pkg::S_CHECK) && check_fin) ||
                                  ((state_r == skis_pkg::S_CMP) && cmp_fin));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skis_pkg::S_IDLE: begin
        if (in_acc) state_nxt = skis_pkg::S_CHECK;
      end
      skis_pkg::S_CHECK: begin
        if (!check_fin) state_nxt = skis_pkg::S_RDIDX;
        else if (fin_go) state_nxt = skis_pkg::S_IDLE;
      end
      skis_pkg::S_RDIDX: begin
        state_nxt = skis_pkg::S_RDKEY;
      end
      skis_pkg::S_RDKEY: begin
        state_nxt = skis_pkg::S_CMP;
      end
      skis_pkg::S_CMP: begin
        if (!cmp_fin) state_nxt = skis_pkg::S_CHECK;
        else if (fin_go) state_nxt = skis_pkg::S_IDLE;
      end
      default: state_nxt = skis_pkg::S_IDLE;
    endcase
  end

  // datapath and memory strobes
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    ks_waddr      = fresh;
    ks_wdata      = KW'(in_data.key_bcd);
    ks_raddr      = so_rdata;
    so_waddr      = SW'(hi_r);
    so_wdata      = fresh;
    so_raddr      = pos_r;
    unique case (state_r)
      skis_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt  = in_data.opcode;
          key_nxt = KW'(in_data.key_bcd);
          lo_nxt  = '0;
          hi_nxt  = count_r;
          ctl.ks_we = (in_data.opcode == skis_pkg::OP_INSERT) && (count_r != CAP_C);
        end
      end
      skis_pkg::S_CHECK: begin
        if (!check_fin) begin
          pos_nxt = (op_r == skis_pkg::OP_INSERT) ? SW'(hi_r - CW'(1)) : mid;
        end else if (fin_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.slot = '0;
          if (op_r == skis_pkg::OP_LOOKUP) begin
            out_data_nxt.status = skis_pkg::ST_MISS;
          end else if (count_r == CAP_C) begin
            out_data_nxt.status = skis_pkg::ST_FULL;
          end else begin
            // new key is the smallest: it goes to the bottom
            ctl.so_we = 1'b1;
            count_nxt = count_r + CW'(1);
            out_data_nxt.status = skis_pkg::ST_OK;
            out_data_nxt.slot   = skis_pkg::SLOT_W'(fresh);
          end
        end
      end
      skis_pkg::S_RDIDX: begin
        ctl.so_re = 1'b1;
      end
      skis_pkg::S_RDKEY: begin
        ctl.ks_re = 1'b1;
        idx_nxt   = so_rdata;
      end
      skis_pkg::S_CMP: begin
        if (op_r == skis_pkg::OP_INSERT) begin
          if (cmp.gt) begin
            // shift larger entry up one place
            ctl.so_we = 1'b1;
            so_wdata  = idx_r;
            hi_nxt    = hi_r - CW'(1);
          end else if (fin_go) begin
            ctl.so_we = 1'b1;
            count_nxt = count_r + CW'(1);
            out_valid_nxt = 1'b1;
            out_data_nxt.status = skis_pkg::ST_OK;
            out_data_nxt.slot   = skis_pkg::SLOT_W'(fresh);
          end
        end else begin
          if (cmp.eq) begin
            if (fin_go) begin
              out_valid_nxt = 1'b1;
              out_data_nxt.status = skis_pkg::ST_OK;
              out_data_nxt.slot   = skis_pkg::SLOT_W'(idx_r);
            end
          end else if (cmp.lt) begin
            lo_nxt = CW'(pos_r) + CW'(1);
          end else begin
            hi_nxt = CW'(pos_r);
          end
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skis_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/skis_check.sv */
module skis_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                out_valid,
  input  logic                out_ready,
  input  skis_pkg::out_word_t out_data
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // slot is zero unless the status is ok
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != skis_pkg::ST_OK) |-> out_data.slot == '0)
    else $error("nonzero slot with miss or full status");

  // the block is busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a word");

  // nothing to deliver after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sorted_key_index_insert_search skis_check u_skis_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
